>>> sv/pafc_pkg.sv
package pafc_pkg;

    localparam int COMPONENT_BITS_DEF = 24;
    localparam int ANGLE_BITS_DEF     = 16;
    localparam int ITERATIONS_DEF     = 16;
    localparam int GUARD_BITS         = 16;
    localparam int ZW                 = 32;
    localparam int TABLE_SIZE         = 24;

    typedef enum logic [2:0]
    {
        KIND_CORDIC,
        KIND_QUARTER,
        KIND_THREE_QUARTER,
        KIND_ZERO,
        KIND_HALF
    } kind_t;

    // atan(2^-i) in units of 2^-32 turn
    function automatic logic [ZW-1:0] step_angle(input int idx);
        logic [ZW-1:0] a;
        begin
            case (idx)
                0:       a = 32'h2000_0000;
                1:       a = 32'h12E4_051E;
                2:       a = 32'h09FB_385B;
                3:       a = 32'h0511_11D4;
                4:       a = 32'h028B_0D43;
                5:       a = 32'h0145_D7E1;
                6:       a = 32'h00A2_F61E;
                7:       a = 32'h0051_7C55;
                8:       a = 32'h0028_BE53;
                9:       a = 32'h0014_5F2F;
                10:      a = 32'h000A_2F98;
                11:      a = 32'h0005_17CC;
                12:      a = 32'h0002_8BE6;
                13:      a = 32'h0001_45F3;
                14:      a = 32'h0000_A2FA;
                15:      a = 32'h0000_517D;
                16:      a = 32'h0000_28BE;
                17:      a = 32'h0000_145F;
                18:      a = 32'h0000_0A30;
                19:      a = 32'h0000_0518;
                20:      a = 32'h0000_028C;
                21:      a = 32'h0000_0146;
                22:      a = 32'h0000_00A3;
                23:      a = 32'h0000_0051;
                default: a = '0;
            endcase
            return a;
        end
    endfunction

endpackage

>>> sv/pafc_pre.sv
module pafc_pre
    import pafc_pkg::*;
#(
    parameter int COMPONENT_BITS = COMPONENT_BITS_DEF,
    parameter int W              = COMPONENT_BITS_DEF + GUARD_BITS + 3
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [COMPONENT_BITS-1:0] re,
    input  logic [COMPONENT_BITS-1:0] im,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic signed [W-1:0]       out_x,
    output logic signed [W-1:0]       out_y,
    output logic [ZW-1:0]             out_z,
    output kind_t                     out_kind
);

    localparam int EXT = W - COMPONENT_BITS - GUARD_BITS;

    logic                valid_reg;
    logic signed [W-1:0] x_reg;
    logic signed [W-1:0] y_reg;
    logic [ZW-1:0]       z_reg;
    kind_t               kind_reg;

    logic signed [W-1:0] x_next;
    logic signed [W-1:0] y_next;
    logic [ZW-1:0]       z_next;
    kind_t               kind_next;
    logic signed [W-1:0] x_scaled;
    logic signed [W-1:0] y_scaled;
    logic                re_neg;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        re_neg   = re[COMPONENT_BITS-1];
        x_scaled = {{EXT{re[COMPONENT_BITS-1]}}, re, {GUARD_BITS{1'b0}}};
        y_scaled = {{EXT{im[COMPONENT_BITS-1]}}, im, {GUARD_BITS{1'b0}}};
        if (re_neg)
        begin
            x_next = -x_scaled;
            y_next = -y_scaled;
            z_next = {1'b1, {(ZW-1){1'b0}}};
        end
        else
        begin
            x_next = x_scaled;
            y_next = y_scaled;
            z_next = '0;
        end
        // axis cases bypass the rotation result
        if (re == '0)
            kind_next = im[COMPONENT_BITS-1] ? KIND_THREE_QUARTER : KIND_QUARTER;
        else if (im == '0)
            kind_next = re_neg ? KIND_HALF : KIND_ZERO;
        else
            kind_next = KIND_CORDIC;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            z_reg    <= z_next;
            kind_reg <= kind_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;
    assign out_z     = z_reg;
    assign out_kind  = kind_reg;

endmodule

>>> sv/pafc_cell.sv
module pafc_cell
    import pafc_pkg::*;
#(
    parameter int W     = COMPONENT_BITS_DEF + GUARD_BITS + 3,
    parameter int STAGE = 0
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic signed [W-1:0] in_x,
    input  logic signed [W-1:0] in_y,
    input  logic [ZW-1:0]       in_z,
    input  kind_t               in_kind,
    output logic                out_valid,
    input  logic                out_ready,
    output logic signed [W-1:0] out_x,
    output logic signed [W-1:0] out_y,
    output logic [ZW-1:0]       out_z,
    output kind_t               out_kind
);

    localparam logic [ZW-1:0] STEP = step_angle(STAGE);

    logic                valid_reg;
    logic signed [W-1:0] x_reg;
    logic signed [W-1:0] y_reg;
    logic [ZW-1:0]       z_reg;
    kind_t               kind_reg;

    logic signed [W-1:0] x_next;
    logic signed [W-1:0] y_next;
    logic [ZW-1:0]       z_next;
    logic signed [W-1:0] dx;
    logic signed [W-1:0] dy;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        dx = in_y >>> STAGE;
        dy = in_x >>> STAGE;
        if (!in_y[W-1])
        begin
            x_next = in_x + dx;
            y_next = in_y - dy;
            z_next = in_z + STEP;
        end
        else
        begin
            x_next = in_x - dx;
            y_next = in_y + dy;
            z_next = in_z - STEP;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            z_reg    <= z_next;
            kind_reg <= in_kind;
        end
    end

    assign out_valid = valid_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;
    assign out_z     = z_reg;
    assign out_kind  = kind_reg;

endmodule

>>> sv/pafc_post.sv
module pafc_post
    import pafc_pkg::*;
#(
    parameter int ANGLE_BITS = ANGLE_BITS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                signed_output,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [ZW-1:0]       in_z,
    input  kind_t               in_kind,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [ANGLE_BITS:0] out_phase
);

    localparam logic [ZW-1:0]         ROUND   = ZW'(1) << (ZW - 1 - ANGLE_BITS);
    localparam logic [ANGLE_BITS-1:0] QUARTER = ANGLE_BITS'(1) << (ANGLE_BITS - 2);
    localparam logic [ANGLE_BITS-1:0] HALF    = ANGLE_BITS'(1) << (ANGLE_BITS - 1);
    localparam logic [ANGLE_BITS:0]   FULL    = (ANGLE_BITS + 1)'(1) << ANGLE_BITS;

    logic                valid_reg;
    logic [ANGLE_BITS:0] phase_reg;
    logic [ANGLE_BITS:0] phase_next;
    logic [ZW-1:0]       z_round;
    logic [ANGLE_BITS-1:0] angle;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        z_round = in_z + ROUND;
        case (in_kind)
            KIND_CORDIC:        angle = z_round[ZW-1 -: ANGLE_BITS];
            KIND_QUARTER:       angle = QUARTER;
            KIND_THREE_QUARTER: angle = QUARTER | HALF;
            KIND_ZERO:          angle = '0;
            KIND_HALF:          angle = HALF;
            default:            angle = '0;
        endcase
        if (signed_output && (angle > HALF))
            phase_next = {1'b0, angle} - FULL;
        else
            phase_next = {1'b0, angle};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            phase_reg <= phase_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_phase = phase_reg;

endmodule

>>> sv/phase_angle_from_complex_top.sv
// Phase of a complex sample as a binary angle (2^ANGLE_BITS units per turn), computed by a
// pipelined vectoring CORDIC: one input stage that folds the left half plane onto the right,
// one cell per iteration, and an output stage that rounds and applies the range mode. One
// transaction is accepted every cycle unless a stalled output backs up to the input. Each
// stage holds its item until the next one has room, so a stalled output lets bubbles ahead
// of it fill. cfg_data bit 0 selects the signed range; the user must write it only while
// the pipeline is empty, as the block itself does not enforce this.
module phase_angle_from_complex_top
    import pafc_pkg::*;
#(
    parameter int COMPONENT_BITS = COMPONENT_BITS_DEF,
    parameter int ANGLE_BITS     = ANGLE_BITS_DEF,
    parameter int ITERATIONS     = ITERATIONS_DEF
)
(
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       s_tvalid,
    output logic                                       s_tready,
    // real_part, imag_part
    input  logic [((2*COMPONENT_BITS+7)/8)*8-1:0]      s_tdata,
    output logic                                       m_tvalid,
    input  logic                                       m_tready,
    // phase
    output logic [((ANGLE_BITS+1+7)/8)*8-1:0]          m_tdata,
    input  logic                                       cfg_valid,
    output logic                                       cfg_ready,
    input  logic [0:0]                                 cfg_data
);

    localparam int W     = COMPONENT_BITS + GUARD_BITS + 3;
    localparam int OUT_W = ((ANGLE_BITS + 1 + 7) / 8) * 8;

    logic                signed_output_reg;

    logic                v_w    [0:ITERATIONS];
    logic                r_w    [0:ITERATIONS];
    logic signed [W-1:0] x_w    [0:ITERATIONS];
    logic signed [W-1:0] y_w    [0:ITERATIONS];
    logic [ZW-1:0]       z_w    [0:ITERATIONS];
    kind_t               kind_w [0:ITERATIONS];
    logic [ANGLE_BITS:0] phase;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            signed_output_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            signed_output_reg <= cfg_data[0];
        end
    end

    pafc_pre #(
        .COMPONENT_BITS (COMPONENT_BITS),
        .W              (W)
    ) u_pre (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .re        (s_tdata[COMPONENT_BITS-1:0]),
        .im        (s_tdata[2*COMPONENT_BITS-1:COMPONENT_BITS]),
        .out_valid (v_w[0]),
        .out_ready (r_w[0]),
        .out_x     (x_w[0]),
        .out_y     (y_w[0]),
        .out_z     (z_w[0]),
        .out_kind  (kind_w[0])
    );

    for (genvar i = 0; i < ITERATIONS; i++)
    begin : g_cell
        pafc_cell #(
            .W     (W),
            .STAGE (i)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (v_w[i]),
            .in_ready  (r_w[i]),
            .in_x      (x_w[i]),
            .in_y      (y_w[i]),
            .in_z      (z_w[i]),
            .in_kind   (kind_w[i]),
            .out_valid (v_w[i+1]),
            .out_ready (r_w[i+1]),
            .out_x     (x_w[i+1]),
            .out_y     (y_w[i+1]),
            .out_z     (z_w[i+1]),
            .out_kind  (kind_w[i+1])
        );
    end

    pafc_post #(
        .ANGLE_BITS (ANGLE_BITS)
    ) u_post (
        .clk           (clk),
        .rst_n         (rst_n),
        .signed_output (signed_output_reg),
        .in_valid      (v_w[ITERATIONS]),
        .in_ready      (r_w[ITERATIONS]),
        .in_z          (z_w[ITERATIONS]),
        .in_kind       (kind_w[ITERATIONS]),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .out_phase     (phase)
    );

    assign m_tdata = OUT_W'(phase);

endmodule

>>> tb/phase_monitor.sv
`timescale 1ns / 100ps

module phase_monitor
#(
    parameter int COMPONENT_BITS = 24,
    parameter int ANGLE_BITS     = 16,
    parameter int ITERATIONS     = 16
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_tvalid,
    input  logic                                  s_tready,
    // real_part, imag_part
    input  logic [((2*COMPONENT_BITS+7)/8)*8-1:0] s_tdata,
    input  logic                                  m_tvalid,
    input  logic                                  m_tready,
    // phase
    input  logic [((ANGLE_BITS+1+7)/8)*8-1:0]     m_tdata,
    input  logic                                  cfg_valid,
    input  logic                                  cfg_ready,
    input  logic [0:0]                            cfg_data,
    output int                                    outstanding,
    output int                                    fail_count
);

    localparam int OW    = ((ANGLE_BITS + 1 + 7) / 8) * 8;
    localparam int SCALE = 16;
    localparam int DEPTH = 64;

    // atan(2^-i) in 2^-32 turn units
    localparam logic [31:0] ATAN_TURN [0:23] = '{
        32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4,
        32'h028B_0D43, 32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55,
        32'h0028_BE53, 32'h0014_5F2F, 32'h000A_2F98, 32'h0005_17CC,
        32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2FA, 32'h0000_517D,
        32'h0000_28BE, 32'h0000_145F, 32'h0000_0A30, 32'h0000_0518,
        32'h0000_028C, 32'h0000_0146, 32'h0000_00A3, 32'h0000_0051
    };

    logic [OW-1:0] phase_q [0:DEPTH-1];
    int            wr_count;
    int            rd_count;
    logic          range_signed;
    int            errors;

    function automatic logic [OW-1:0] phase_of(input logic signed [COMPONENT_BITS-1:0] re,
                                               input logic signed [COMPONENT_BITS-1:0] im,
                                               input logic signed_range);
        longint signed       x;
        longint signed       y;
        longint signed       dx;
        longint signed       dy;
        logic [31:0]         z;
        logic [32:0]         rounded;
        logic [ANGLE_BITS:0] turn;
        logic [ANGLE_BITS:0] half;
        logic [ANGLE_BITS:0] result;
        turn = (ANGLE_BITS+1)'(1) << ANGLE_BITS;
        half = turn >> 1;
        if (re == 0)
        begin
            result = (im >= 0) ? (turn >> 2) : ((turn >> 2) | (turn >> 1));
        end
        else if (im == 0)
        begin
            result = (re > 0) ? '0 : half;
        end
        else
        begin
            x = longint'(re) * (longint'(1) << SCALE);
            y = longint'(im) * (longint'(1) << SCALE);
            z = '0;
            // left half plane: rotate by half a turn first
            if (re < 0)
            begin
                x = -x;
                y = -y;
                z = 32'h8000_0000;
            end
            for (int i = 0; i < ITERATIONS && i < 24; i++)
            begin
                dx = y >>> i;
                dy = x >>> i;
                if (y >= 0)
                begin
                    x = x + dx;
                    y = y - dy;
                    z = z + ATAN_TURN[i];
                end
                else
                begin
                    x = x - dx;
                    y = y + dy;
                    z = z - ATAN_TURN[i];
                end
            end
            rounded = {1'b0, z} + (33'd1 << (31 - ANGLE_BITS));
            result  = {1'b0, rounded[31 -: ANGLE_BITS]};
        end
        result[ANGLE_BITS] = 1'b0;
        if (signed_range && result > half)
            result = result - turn;
        return OW'(result);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        logic [OW-1:0] want;
        if (!rst_n)
        begin
            wr_count     = 0;
            rd_count     = 0;
            range_signed = 1'b0;
            errors       = 0;
            outstanding <= 0;
            fail_count  <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                phase_q[wr_count % DEPTH] = phase_of(s_tdata[COMPONENT_BITS-1:0],
                                                     s_tdata[2*COMPONENT_BITS-1:COMPONENT_BITS],
                                                     range_signed);
                wr_count++;
            end
            if (m_tvalid && m_tready)
            begin
                if (wr_count == rd_count)
                begin
                    errors++;
                    $display("%0t unexpected phase transaction: expected none, actual %0d",
                             $time, $signed(m_tdata[ANGLE_BITS:0]));
                end
                else
                begin
                    want = phase_q[rd_count % DEPTH];
                    rd_count++;
                    if (m_tdata !== want)
                    begin
                        errors++;
                        $display("%0t phase mismatch: expected %0d (%h), actual %0d (%h)",
                                 $time, $signed(want[ANGLE_BITS:0]), want,
                                 $signed(m_tdata[ANGLE_BITS:0]), m_tdata);
                    end
                end
            end
            if (cfg_valid && cfg_ready)
                range_signed = cfg_data[0];
            outstanding <= wr_count - rd_count;
            fail_count  <= errors;
        end
    end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import pafc_pkg::*;

    localparam int CB       = COMPONENT_BITS_DEF;
    localparam int AB       = ANGLE_BITS_DEF;
    localparam int LAT      = ITERATIONS_DEF + 2;
    localparam int IW       = ((2 * CB + 7) / 8) * 8;
    localparam int OW       = ((AB + 1 + 7) / 8) * 8;
    localparam int N_RANDOM = 1350;
    localparam int N_PHASES = 6;
    localparam int LIMIT    = 400000;
    localparam int N_DIR    = 22;

    localparam logic signed [CB-1:0] VMAX = {1'b0, {(CB-1){1'b1}}};
    localparam logic signed [CB-1:0] VMIN = {1'b1, {(CB-1){1'b0}}};
    localparam logic signed [CB-1:0] ONE  = CB'(1);
    localparam logic signed [CB-1:0] NEG1 = CB'(-1);
    localparam logic signed [CB-1:0] ZERO = '0;

    localparam logic signed [CB-1:0] DIR_RE [0:N_DIR-1] = '{
        ZERO, ZERO, ZERO, ZERO, VMAX, VMIN, ONE, NEG1, VMAX, VMIN, VMAX,
        VMIN, ONE, NEG1, ONE, NEG1, VMAX, VMIN, VMIN, CB'(5), CB'(-7), VMAX
    };
    localparam logic signed [CB-1:0] DIR_IM [0:N_DIR-1] = '{
        ZERO, VMAX, VMIN, NEG1, ZERO, ZERO, ZERO, ZERO, VMAX, VMIN, VMIN,
        VMAX, ONE, NEG1, NEG1, ONE, NEG1, NEG1, ONE, CB'(-3), CB'(2), ONE
    };

    logic          clk       = 1'b0;
    logic          rst_n     = 1'b0;
    logic          s_tvalid  = 1'b0;
    logic          s_tready;
    logic [IW-1:0] s_tdata   = '0;
    logic          m_tvalid;
    logic          m_tready  = 1'b0;
    logic [OW-1:0] m_tdata;
    logic          cfg_valid = 1'b0;
    logic          cfg_ready;
    logic [0:0]    cfg_data  = '0;
    int            outstanding;
    int            fail_count;

    int            burst_left = 0;
    int            rx_cycle   = 0;
    int            rx_pattern = 0;
    int            rx_hold    = 0;

    always #5 clk = ~clk;

    phase_angle_from_complex_top u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    phase_monitor
    #(
        .COMPONENT_BITS (CB),
        .ANGLE_BITS     (AB),
        .ITERATIONS     (ITERATIONS_DEF)
    )
    u_mon
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .outstanding (outstanding),
        .fail_count  (fail_count)
    );

    // receiver backpressure from one of four randomly chosen patterns
    always @(posedge clk)
    begin
        rx_cycle++;
        if (rx_cycle % 256 == 0)
            rx_pattern = $urandom_range(0, 3);
        case (rx_pattern)
            0: m_tready <= 1'b1;
            1: m_tready <= 1'($urandom_range(0, 1));
            2:
            begin
                if (rx_hold > 0)
                begin
                    rx_hold--;
                    m_tready <= 1'b0;
                end
                else
                begin
                    if ($urandom_range(0, 15) == 0)
                        rx_hold = $urandom_range(1, 20);
                    m_tready <= 1'b1;
                end
            end
            default: m_tready <= (rx_cycle % 3 != 0);
        endcase
    end

    function automatic logic signed [CB-1:0] pick_component();
        case ($urandom_range(0, 7))
            0:       return ZERO;
            1:       return VMAX;
            2:       return VMIN;
            3:       return CB'($signed($urandom_range(0, 16)) - 8);
            default: return CB'($urandom());
        endcase
    endfunction

    task automatic send_vector(input logic signed [CB-1:0] re, input logic signed [CB-1:0] im);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 6);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 32);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= IW'({im, re});
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        burst_left--;
    endtask

    task automatic write_range(input logic signed_range);
        s_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (LAT + 4) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= signed_range;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        repeat (LIMIT) @(posedge clk);
        $display("Mismatches found");
        $finish;
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed corners in signed range
        write_range(1'b1);
        for (int i = 0; i < N_DIR; i++)
            send_vector(DIR_RE[i], DIR_IM[i]);

        for (int p = 0; p < N_PHASES; p++)
        begin
            write_range(p[0]);
            for (int i = 0; i < N_RANDOM / N_PHASES; i++)
                send_vector(pick_component(), pick_component());
        end

        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (LAT + 10) @(posedge clk);
        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

>>> filelist.f
sv/pafc_pkg.sv
sv/pafc_pre.sv
sv/pafc_cell.sv
sv/pafc_post.sv
sv/phase_angle_from_complex_top.sv
tb/phase_monitor.sv
tb/tb_top.sv
